// ===== rtl/ctsd_pkg.sv =====
// Shared types, constants and helpers for the ternary census stereo block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ctsd_pkg;

   // Census window geometry
   localparam int WIN_HALF_W = 4;
   localparam int WIN_HALF_H = 8;
   localparam int WIN_COLS   = 2 * WIN_HALF_W + 1;
   localparam int WIN_ROWS   = 2 * WIN_HALF_H + 1;
   localparam int WIN_SIZE   = WIN_COLS * WIN_ROWS;

   // Frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MIN_WIDTH  = 32;
   localparam int MIN_HEIGHT = 17;
   localparam int MAX_HEIGHT = 1024;
   localparam int DISP_MAX   = 63;

   // Circular pixel store
   localparam int STORE_DEPTH = WIN_ROWS * MAX_WIDTH + 2 * WIN_HALF_W + DISP_MAX + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Counter widths
   localparam int POS_W  = 21;
   localparam int CNT_W  = $clog2(WIN_SIZE + 1);
   localparam int COL_W  = $clog2(WIN_COLS);
   localparam int COST_W = $clog2(WIN_SIZE + 1);
   localparam int TRITS_W = 2 * WIN_SIZE;

   // Register indexes
   localparam logic [1:0] REG_WIDTH     = 2'd0;
   localparam logic [1:0] REG_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_MAX_DISP  = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   // Request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Trit codes
   localparam logic [1:0] TRIT_LO  = 2'd0;
   localparam logic [1:0] TRIT_MID = 2'd1;
   localparam logic [1:0] TRIT_HI  = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
      logic [5:0]  max_disp;
      logic [7:0]  threshold;
   } cfg_type;

   typedef struct packed {
      addr_type    tl;
      addr_type    ctr;
      logic [9:0]  col;
      logic [9:0]  row;
      logic        border;
      logic        last;
   } job_type;

   // Add two store addresses modulo the store depth
   function automatic addr_type add_wrap(addr_type a, addr_type b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ADDR_W + 1)'(STORE_DEPTH)) begin
         s = s - (ADDR_W + 1)'(STORE_DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

// ===== rtl/ctsd_front.sv =====
// Front end: configuration registers, input handshake, pixel store writes
// and scheduling of result jobs. Depends on ctsd_pkg.
`timescale 1ns / 1ps

module ctsd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [7:0]             req_left_pixel,
   input  logic [7:0]             req_right_pixel,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [10:0]            csr_wdata,
   input  logic                   q_full,
   output logic                   q_push,
   output ctsd_pkg::job_type      q_job,
   output logic                   st_we,
   output ctsd_pkg::addr_type     st_waddr,
   output logic [7:0]             st_left,
   output logic [7:0]             st_right,
   output ctsd_pkg::cfg_type      cfg
);

   logic [10:0] width_ff, width_in;
   logic [10:0] height_ff, height_in;
   logic [5:0]  max_disp_ff, max_disp_in;
   logic [7:0]  thresh_ff, thresh_in;

   logic [ctsd_pkg::POS_W-1:0] in_pos_ff, in_pos_in;
   logic [ctsd_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic [9:0]                 col_ff, col_in;
   logic [9:0]                 row_ff, row_in;
   ctsd_pkg::addr_type         wptr_ff, wptr_in;
   ctsd_pkg::addr_type         optr_ff, optr_in;

   logic [10:0]                w_eff;
   logic [10:0]                h_eff;
   logic [21:0]                prod;
   logic [ctsd_pkg::POS_W-1:0] total;
   logic [ctsd_pkg::POS_W-1:0] lag;
   logic [ctsd_pkg::POS_W-1:0] in_nxt;
   logic                       accept;
   logic                       take_pix;
   logic                       emit;
   logic                       frame_end;
   logic                       interior;
   ctsd_pkg::addr_type         koff;
   ctsd_pkg::addr_type         tl;

   // Saturate frame size
   always_comb begin
      w_eff = width_ff;
      if (width_ff < 11'(ctsd_pkg::MIN_WIDTH)) begin
         w_eff = 11'(ctsd_pkg::MIN_WIDTH);
      end else if (width_ff > 11'(ctsd_pkg::MAX_WIDTH)) begin
         w_eff = 11'(ctsd_pkg::MAX_WIDTH);
      end
      h_eff = height_ff;
      if (height_ff < 11'(ctsd_pkg::MIN_HEIGHT)) begin
         h_eff = 11'(ctsd_pkg::MIN_HEIGHT);
      end else if (height_ff > 11'(ctsd_pkg::MAX_HEIGHT)) begin
         h_eff = 11'(ctsd_pkg::MAX_HEIGHT);
      end
   end

   // The 6-bit field never exceeds the disparity limit
   assign cfg = '{width: w_eff, height: h_eff, max_disp: max_disp_ff, threshold: thresh_ff};

   assign prod  = {11'd0, w_eff} * {11'd0, h_eff};
   assign total = prod[ctsd_pkg::POS_W-1:0];
   assign lag   = ctsd_pkg::POS_W'(ctsd_pkg::WIN_HALF_H) * ctsd_pkg::POS_W'(w_eff)
                + ctsd_pkg::POS_W'(ctsd_pkg::WIN_HALF_W) + ctsd_pkg::POS_W'(max_disp_ff);

   // Classify the beat
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign take_pix  = accept && (req_type == ctsd_pkg::REQ_PIXEL) && (in_pos_ff < total);
   assign in_nxt    = in_pos_ff + ctsd_pkg::POS_W'(take_pix);

   always_comb begin
      emit = 1'b0;
      if (accept) begin
         if (in_nxt >= total) begin
            emit = out_pos_ff < total;
         end else begin
            emit = (out_pos_ff + lag) < in_nxt;
         end
      end
   end

   assign frame_end = emit && ((out_pos_ff + 1'b1) >= total);

   assign interior = (row_ff >= 10'(ctsd_pkg::WIN_HALF_H))
                  && ({2'b0, row_ff} + 12'(ctsd_pkg::WIN_HALF_H) < {1'b0, h_eff})
                  && (col_ff >= 10'(ctsd_pkg::WIN_HALF_W))
                  && ({2'b0, col_ff} + 12'(ctsd_pkg::WIN_HALF_W) + {6'd0, max_disp_ff}
                      < {1'b0, w_eff});

   // Top-left corner of the window, modulo the store depth
   assign koff = ctsd_pkg::ADDR_W'(ctsd_pkg::WIN_HALF_H) * ctsd_pkg::ADDR_W'(w_eff)
               + ctsd_pkg::ADDR_W'(ctsd_pkg::WIN_HALF_W);
   assign tl   = (optr_ff >= koff) ? (optr_ff - koff)
               : (ctsd_pkg::ADDR_W'(ctsd_pkg::STORE_DEPTH) - koff + optr_ff);

   assign q_push = emit;
   assign q_job  = '{tl: tl, ctr: optr_ff, col: col_ff, row: row_ff,
                     border: !interior, last: (out_pos_ff == total - 1'b1)};

   assign st_we    = take_pix;
   assign st_waddr = wptr_ff;
   assign st_left  = req_left_pixel;
   assign st_right = req_right_pixel;

   // Next state of positions and registers
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      max_disp_in = max_disp_ff;
      thresh_in   = thresh_ff;
      in_pos_in   = in_pos_ff;
      out_pos_in  = out_pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      wptr_in     = wptr_ff;
      optr_in     = optr_ff;
      if (csr_write_en) begin
         case (csr_index)
            ctsd_pkg::REG_WIDTH:     width_in    = csr_wdata;
            ctsd_pkg::REG_HEIGHT:    height_in   = csr_wdata;
            ctsd_pkg::REG_MAX_DISP:  max_disp_in = csr_wdata[5:0];
            ctsd_pkg::REG_THRESHOLD: thresh_in   = csr_wdata[7:0];
            default:                 width_in    = width_ff;
         endcase
         in_pos_in  = '0;
         out_pos_in = '0;
         col_in     = '0;
         row_in     = '0;
         optr_in    = wptr_ff;
      end else begin
         if (take_pix) begin
            wptr_in   = ctsd_pkg::add_wrap(wptr_ff, ctsd_pkg::ADDR_W'(1));
            in_pos_in = in_nxt;
         end
         if (emit) begin
            optr_in    = ctsd_pkg::add_wrap(optr_ff, ctsd_pkg::ADDR_W'(1));
            out_pos_in = out_pos_ff + 1'b1;
            if ({1'b0, col_ff} + 11'd1 == w_eff) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         if (frame_end) begin
            in_pos_in  = '0;
            out_pos_in = '0;
            col_in     = '0;
            row_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd640;
         height_ff   <= 11'd480;
         max_disp_ff <= 6'd50;
         thresh_ff   <= 8'd1;
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         wptr_ff     <= '0;
         optr_ff     <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         max_disp_ff <= max_disp_in;
         thresh_ff   <= thresh_in;
         in_pos_ff   <= in_pos_in;
         out_pos_ff  <= out_pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         wptr_ff     <= wptr_in;
         optr_ff     <= optr_in;
      end
   end

endmodule

// ===== rtl/ctsd_queue.sv =====
// Two-entry job queue between the front end and the matching engine.
// Depends on ctsd_pkg for the job type.
`timescale 1ns / 1ps

module ctsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ctsd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output ctsd_pkg::job_type pop_job,
   output logic              empty
);

   ctsd_pkg::job_type slot_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;

   assign full    = cnt_ff[1];
   assign empty   = (cnt_ff == 2'd0);
   assign pop_job = slot_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/ctsd_back.sv =====
// Matching engine: pixel stores, census window walks, disparity search
// and the result register. Depends on ctsd_pkg.
`timescale 1ns / 1ps

module ctsd_back (
   input  logic               clock,
   input  logic               reset,
   input  ctsd_pkg::cfg_type  cfg,
   input  logic               q_empty,
   output logic               q_pop,
   input  ctsd_pkg::job_type  q_job,
   input  logic               st_we,
   input  ctsd_pkg::addr_type st_waddr,
   input  logic [7:0]         st_left,
   input  logic [7:0]         st_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_disparity,
   output logic [9:0]         rsp_out_col,
   output logic [9:0]         rsp_out_row,
   output logic               rsp_is_border,
   output logic               rsp_last_of_frame
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RC   = 6'b000010,
      S_RW   = 6'b000100,
      S_LC   = 6'b001000,
      S_LW   = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   function automatic logic [1:0] trit_of(logic [7:0] n, logic [7:0] c, logic [7:0] t);
      logic signed [9:0] diff;
      logic signed [9:0] thr;
      diff = signed'({2'b00, n}) - signed'({2'b00, c});
      thr  = signed'({2'b00, t});
      if (diff > thr) begin
         return ctsd_pkg::TRIT_HI;
      end else if (diff < -thr) begin
         return ctsd_pkg::TRIT_LO;
      end
      return ctsd_pkg::TRIT_MID;
   endfunction

   logic [7:0] left_mem  [ctsd_pkg::STORE_DEPTH];
   logic [7:0] right_mem [ctsd_pkg::STORE_DEPTH];
   logic [7:0] lq_ff;
   logic [7:0] rq_ff;

   state_type                    state_ff, state_in;
   ctsd_pkg::job_type            job_ff, job_in;
   logic [5:0]                   d_ff, d_in;
   logic [5:0]                   best_d_ff, best_d_in;
   logic [ctsd_pkg::COST_W-1:0]  best_cost_ff, best_cost_in;
   logic [ctsd_pkg::COST_W-1:0]  cost_ff, cost_in;
   logic [ctsd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ctsd_pkg::COL_W-1:0]   col_ff, col_in;
   ctsd_pkg::addr_type           rp_ff, rp_in;
   ctsd_pkg::addr_type           cp_ff, cp_in;
   logic                         rdv_ff, rdv_in;
   logic                         cpend_ff, cpend_in;
   logic [7:0]                   ctr_px_ff, ctr_px_in;
   logic [ctsd_pkg::TRITS_W-1:0] code_ff, code_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [5:0]                   disp_ff, disp_in;
   logic [9:0]                   ocol_ff, ocol_in;
   logic [9:0]                   orow_ff, orow_in;
   logic                         obord_ff, obord_in;
   logic                         olast_ff, olast_in;

   ctsd_pkg::addr_type           rd_addr;
   ctsd_pkg::addr_type           rp_step;
   logic [7:0]                   data;
   logic [1:0]                   new_trit;
   logic                         mism;
   logic [ctsd_pkg::COST_W-1:0]  cost_sum;
   logic                         issuing;
   logic                         walk_done;
   logic                         walking;

   // Pixel stores: one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (st_we) begin
         left_mem[st_waddr]  <= st_left;
         right_mem[st_waddr] <= st_right;
      end
      lq_ff <= left_mem[rd_addr];
      rq_ff <= right_mem[rd_addr];
   end

   // Read address: window centre on entry, walk pointer otherwise
   always_comb begin
      case (state_ff)
         S_RC:    rd_addr = job_ff.ctr;
         S_LC:    rd_addr = ctsd_pkg::add_wrap(job_ff.ctr, ctsd_pkg::ADDR_W'(d_ff));
         default: rd_addr = cp_ff;
      endcase
   end

   assign walking   = (state_ff == S_RW) || (state_ff == S_LW);
   assign issuing   = walking && (cnt_ff < ctsd_pkg::CNT_W'(ctsd_pkg::WIN_SIZE));
   assign walk_done = (cnt_ff == ctsd_pkg::CNT_W'(ctsd_pkg::WIN_SIZE)) && rdv_ff;
   assign rp_step   = ctsd_pkg::add_wrap(rp_ff, ctsd_pkg::ADDR_W'(cfg.width));
   assign data      = (state_ff == S_RW) ? rq_ff : lq_ff;
   assign new_trit  = trit_of(data, ctr_px_ff, cfg.threshold);
   assign mism      = (new_trit != code_ff[1:0]);
   assign cost_sum  = cost_ff + ctsd_pkg::COST_W'(mism);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      d_in         = d_ff;
      best_d_in    = best_d_ff;
      best_cost_in = best_cost_ff;
      cost_in      = cost_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      rp_in        = rp_ff;
      cp_in        = cp_ff;
      rdv_in       = 1'b0;
      cpend_in     = 1'b0;
      ctr_px_in    = ctr_px_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      disp_in      = disp_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      obord_in     = obord_ff;
      olast_in     = olast_ff;
      q_pop        = 1'b0;

      case (state_ff)
         // Take the next job; border pixels skip the search
         S_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               job_in       = q_job;
               d_in         = '0;
               best_d_in    = '0;
               best_cost_in = '1;
               state_in     = q_job.border ? S_EMIT : S_RC;
            end
         end
         S_RC: begin
            cpend_in = 1'b1;
            cnt_in   = '0;
            col_in   = '0;
            rp_in    = job_ff.tl;
            cp_in    = job_ff.tl;
            state_in = S_RW;
         end
         S_LC: begin
            cpend_in = 1'b1;
            cnt_in   = '0;
            col_in   = '0;
            cost_in  = '0;
            rp_in    = ctsd_pkg::add_wrap(job_ff.tl, ctsd_pkg::ADDR_W'(d_ff));
            cp_in    = ctsd_pkg::add_wrap(job_ff.tl, ctsd_pkg::ADDR_W'(d_ff));
            state_in = S_LW;
         end
         S_RW, S_LW: begin
            if (cpend_ff) begin
               ctr_px_in = data;
            end
            // Advance the walk one pixel, row by row
            if (issuing) begin
               rdv_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (col_ff == ctsd_pkg::COL_W'(ctsd_pkg::WIN_COLS - 1)) begin
                  col_in = '0;
                  rp_in  = rp_step;
                  cp_in  = rp_step;
               end else begin
                  col_in = col_ff + 1'b1;
                  cp_in  = ctsd_pkg::add_wrap(cp_ff, ctsd_pkg::ADDR_W'(1));
               end
            end
            // Shift in right trits, rotate them past the left ones
            if (rdv_ff) begin
               if (state_ff == S_RW) begin
                  code_in = {new_trit, code_ff[ctsd_pkg::TRITS_W-1:2]};
               end else begin
                  code_in = {code_ff[1:0], code_ff[ctsd_pkg::TRITS_W-1:2]};
                  cost_in = cost_sum;
               end
            end
            if (walk_done) begin
               if (state_ff == S_RW) begin
                  state_in = S_LC;
               end else begin
                  if (cost_sum < best_cost_ff) begin
                     best_cost_in = cost_sum;
                     best_d_in    = d_ff;
                  end
                  if (d_ff == cfg.max_disp) begin
                     state_in = S_EMIT;
                  end else begin
                     d_in     = d_ff + 1'b1;
                     state_in = S_LC;
                  end
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               disp_in      = job_ff.border ? 6'd0 : best_d_ff;
               ocol_in      = job_ff.col;
               orow_in      = job_ff.row;
               obord_in     = job_ff.border;
               olast_in     = job_ff.last;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rdv_ff       <= 1'b0;
         cpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         cpend_ff     <= cpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      d_ff         <= d_in;
      best_d_ff    <= best_d_in;
      best_cost_ff <= best_cost_in;
      cost_ff      <= cost_in;
      cnt_ff       <= cnt_in;
      col_ff       <= col_in;
      rp_ff        <= rp_in;
      cp_ff        <= cp_in;
      ctr_px_ff    <= ctr_px_in;
      code_ff      <= code_in;
      disp_ff      <= disp_in;
      ocol_ff      <= ocol_in;
      orow_ff      <= orow_in;
      obord_ff     <= obord_in;
      olast_ff     <= olast_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_disparity     = disp_ff;
   assign rsp_out_col       = ocol_ff;
   assign rsp_out_row       = orow_ff;
   assign rsp_is_border     = obord_ff;
   assign rsp_last_of_frame = olast_ff;

endmodule

// ===== rtl/ternary_census_stereo_disparity.sv =====
// Top level of the ternary census stereo disparity block.
// Depends on ctsd_pkg, ctsd_front, ctsd_queue and ctsd_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_type, req_left_pixel, req_right_pixel
//   rsp_      out        rsp_valid / rsp_ready  disparity, out_col, out_row, is_border, last
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// A border result skips the search in the engine. An interior result walks the
// window once for the right image and once per disparity up to max_disparity,
// via the single read port of each pixel store: one window pixel per cycle, 153 per walk.
// Reset is synchronous; the pixel stores are not cleared.
// A two-beat job queue lets input beats be taken while the engine works or the
// result register waits; input stalls only when that queue is full.
`timescale 1ns / 1ps

module ternary_census_stereo_disparity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_left_pixel,
   input  logic [7:0]  req_right_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_disparity,
   output logic [9:0]  rsp_out_col,
   output logic [9:0]  rsp_out_row,
   output logic        rsp_is_border,
   output logic        rsp_last_of_frame,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   ctsd_pkg::cfg_type  cfg;
   ctsd_pkg::job_type  push_job;
   ctsd_pkg::job_type  pop_job;
   ctsd_pkg::addr_type st_waddr;
   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   logic               st_we;
   logic [7:0]         st_left;
   logic [7:0]         st_right;

   ctsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_left_pixel  (req_left_pixel),
      .req_right_pixel (req_right_pixel),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job),
      .st_we           (st_we),
      .st_waddr        (st_waddr),
      .st_left         (st_left),
      .st_right        (st_right),
      .cfg             (cfg)
   );

   ctsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   ctsd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_job             (pop_job),
      .st_we             (st_we),
      .st_waddr          (st_waddr),
      .st_left           (st_left),
      .st_right          (st_right),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_disparity     (rsp_disparity),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_is_border     (rsp_is_border),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
